// ----- hdl/rmes_pkg.sv -----
// ----------------------------------------------------------------------------
// rmes_pkg
// Shared types, constants and helpers of the periodic job scheduler.
// ----------------------------------------------------------------------------
package rmes_pkg;

  localparam int MaxTasks = 8;
  localparam int MaxJobs  = 16;
  localparam int TimeBits = 32;
  localparam int TaskIdxW = $clog2(MaxTasks);
  localparam int TaskCntW = TaskIdxW + 1;
  localparam int JobIdxW  = $clog2(MaxJobs);
  localparam int JobCntW  = JobIdxW + 1;

  typedef enum logic [1:0] {
    KindLoad = 2'd0,
    KindMiss = 2'd1,
    KindRun  = 2'd2,
    KindIdle = 2'd3
  } kind_e;

  typedef enum logic {
    OpLoad = 1'b0,
    OpTick = 1'b1
  } op_e;

  localparam logic [1:0] RegPolicy    = 2'd0;
  localparam logic [1:0] RegKillLate  = 2'd1;
  localparam logic [1:0] RegStartTime = 2'd2;
  localparam logic [1:0] RegTaskCount = 2'd3;

  typedef struct packed {
    logic        policy;
    logic        kill_late;
    logic [31:0] time_base;
    logic [3:0]  task_count;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [2:0]  task_index;
    logic [15:0] task_start;
    logic [15:0] task_period;
    logic [15:0] task_exec;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  task_id;
    logic [15:0] job_id;
    logic [15:0] exec_done;
    logic [15:0] exec_total;
    logic [31:0] tick_time;
    logic [31:0] miss_total;
    logic [31:0] busy_total;
    logic        job_overflow;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [TaskIdxW-1:0] task_idx;
    logic [15:0]         number;
    logic [15:0]         executed;
    logic [TimeBits-1:0] deadline;
    logic [15:0]         period;
    logic [15:0]         total;
  } job_t;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic job_before(logic pol, job_t a, job_t b);
    logic [TimeBits-1:0] ka;
    logic [TimeBits-1:0] kb;
    ka = pol ? a.deadline : TimeBits'(a.period);
    kb = pol ? b.deadline : TimeBits'(b.period);
    if (ka != kb) return ka < kb;
    if (a.number != b.number) return a.number < b.number;
    return a.task_idx < b.task_idx;
  endfunction

endpackage

// ----- hdl/rmes_if.sv -----
// ----------------------------------------------------------------------------
// rmes_if
// Valid/ready channels of the scheduler: command input and result output.
// ----------------------------------------------------------------------------
interface rmes_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [2:0]  task_index;
  logic [15:0] task_start;
  logic [15:0] task_period;
  logic [15:0] task_exec;
  modport source (output valid, op, task_index, task_start, task_period, task_exec,
                  input ready);
  modport sink (input valid, op, task_index, task_start, task_period, task_exec,
                output ready);
endinterface

interface rmes_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  task_id;
  logic [15:0] job_id;
  logic [15:0] exec_done;
  logic [15:0] exec_total;
  logic [31:0] tick_time;
  logic [31:0] miss_total;
  logic [31:0] busy_total;
  logic        job_overflow;
  logic        last;
  modport source (output valid, kind, task_id, job_id, exec_done, exec_total, tick_time,
                  miss_total, busy_total, job_overflow, last, input ready);
  modport sink (input valid, kind, task_id, job_id, exec_done, exec_total, tick_time,
                miss_total, busy_total, job_overflow, last, output ready);
endinterface

// ----- hdl/rm_edf_job_scheduler.sv -----
// ----------------------------------------------------------------------------
// rm_edf_job_scheduler
// Periodic job scheduler, rate monotonic or earliest deadline first.
//
//   channel   dir  handshake             payload
//   in_if     in   valid/ready           op, task_index, task_start/period/exec
//   out_if    out  valid/ready           kind .. last, up to 17 per tick
//   apb       in   psel/penable/pwrite   4 registers at 4*i
//
// A load writes the task table and emits one result. A tick runs the drop pass,
// one ordering pass per missed job plus one that ends ordering, a bit-serial
// remainder for each task in use whose start has passed (tasks not yet started
// are skipped), the dispatch pass, then the results as the output takes them.
// Reset clears valid bits and counters at once; no clearing pass.
// A two-entry command queue and an output register let either side stall.
// ----------------------------------------------------------------------------
module rm_edf_job_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmes_in_if.sink     in_if,
  rmes_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rmes_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;
  res_t res;

  rmes_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rmes_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  rmes_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .res_o       (res),
    .res_valid_o (out_if.valid),
    .res_ready_i (out_if.ready)
  );

  assign out_if.kind         = res.kind;
  assign out_if.task_id      = res.task_id;
  assign out_if.job_id       = res.job_id;
  assign out_if.exec_done    = res.exec_done;
  assign out_if.exec_total   = res.exec_total;
  assign out_if.tick_time    = res.tick_time;
  assign out_if.miss_total   = res.miss_total;
  assign out_if.busy_total   = res.busy_total;
  assign out_if.job_overflow = res.job_overflow;
  assign out_if.last         = res.last;

endmodule

// ----- hdl/rmes_cfg.sv -----
// ----------------------------------------------------------------------------
// rmes_cfg
// APB register file: policy, kill_late, time base, task_count.
// ----------------------------------------------------------------------------
module rmes_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output rmes_pkg::cfg_t    cfg_o
);
  import rmes_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.policy     <= 1'b0;
      cfg_q.kill_late  <= 1'b0;
      cfg_q.time_base  <= 32'd0;
      cfg_q.task_count <= 4'd1;
    end else if (wr_en) begin
      case (reg_idx)
        RegPolicy:    cfg_q.policy     <= pwdata[0];
        RegKillLate:  cfg_q.kill_late  <= pwdata[0];
        RegStartTime: cfg_q.time_base  <= pwdata;
        RegTaskCount: cfg_q.task_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegPolicy:    prdata = {31'd0, cfg_q.policy};
      RegKillLate:  prdata = {31'd0, cfg_q.kill_late};
      RegStartTime: prdata = cfg_q.time_base;
      RegTaskCount: prdata = {28'd0, cfg_q.task_count};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

// ----- hdl/rmes_front.sv -----
// ----------------------------------------------------------------------------
// rmes_front
// Accepts commands, cleans up load fields, and queues them for the engine.
// ----------------------------------------------------------------------------
module rmes_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  rmes_in_if.sink        in_if,
  output rmes_pkg::cmd_t cmd_o,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i
);
  import rmes_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.op          = op_e'(in_if.op);
    cmd_in.task_index  = in_if.task_index;
    cmd_in.task_start  = in_if.task_start;
    cmd_in.task_period = (in_if.task_period == 16'd0) ? 16'd1 : in_if.task_period;
    cmd_in.task_exec   = in_if.task_exec;
  end

  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("command queue count out of range");

endmodule

// ----- hdl/rmes_mod.sv -----
// ----------------------------------------------------------------------------
// rmes_mod
// Bit-serial remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmes_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rmes_pkg::TimeBits-1:0] dividend_i,
  input  logic [15:0]                   divisor_i,
  output logic                          done_o,
  output logic [15:0]                   rem_o
);
  import rmes_pkg::*;

  localparam int CntW = $clog2(TimeBits);

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [TimeBits-1:0] div_q;
  logic [15:0]         rem_q;
  logic [15:0]         dsr_q;
  logic [16:0]         r2;
  logic [16:0]         r3;

  assign r2     = {rem_q, div_q[TimeBits-1]};
  assign r3     = (r2 >= {1'b0, dsr_q}) ? r2 - {1'b0, dsr_q} : r2;
  assign done_o = done_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= dividend_i;
      rem_q <= 16'd0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      div_q <= div_q << 1;
      rem_q <= r3[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntW'(TimeBits - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(TimeBits - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hdl/rmes_back.sv -----
// ----------------------------------------------------------------------------
// rmes_back
// Scheduling engine: task loads, job store, drop pass, miss ordering, releases, dispatch, results.
// ----------------------------------------------------------------------------
module rmes_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rmes_pkg::cfg_t cfg_i,
  input  rmes_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  output rmes_pkg::res_t res_o,
  output logic           res_valid_o,
  input  logic           res_ready_i
);
  import rmes_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SDropRd, SDropEv, SSortRd, SSortEv, SSortPut, SRelTest, SRelWait,
    SRelPut, SSelRd, SSelEv, SSelPut, SEmitMiss, SEmitRun, SEmitLoad
  } state_e;

  state_e              state_q;
  cmd_t                cmd_q;
  job_t                mem_q [MaxJobs];
  job_t                rd_q;
  logic                mem_we;
  logic [JobIdxW-1:0]  mem_wa;
  job_t                mem_wd;
  logic [MaxJobs-1:0]  valid_q;
  logic [MaxJobs-1:0]  flag_q;
  logic [JobIdxW-1:0]  idx_q;
  logic [JobIdxW-1:0]  best_idx_q;
  job_t                best_q;
  logic                found_q;
  job_t                mbuf_q [MaxJobs];
  logic [JobCntW-1:0]  nmiss_q;
  logic [JobCntW-1:0]  emit_q;
  logic [TaskCntW-1:0] tcnt_q;
  logic [15:0]         tstart_q [MaxTasks];
  logic [15:0]         tper_q [MaxTasks];
  logic [15:0]         texec_q [MaxTasks];
  logic [15:0]         trel_q [MaxTasks];
  logic [TimeBits-1:0] now_q;
  logic                started_q;
  logic [31:0]         miss_cnt_q;
  logic [31:0]         busy_cnt_q;
  logic                ovf_q;
  res_t                out_q;
  logic                out_v_q;
  logic                out_free;
  logic                emit_fire;
  logic                last_idx;
  logic                free_found;
  logic [JobIdxW-1:0]  free_idx;
  logic [TaskCntW-1:0] ntasks;
  logic [TaskIdxW-1:0] tsel;
  logic                mod_start;
  logic                mod_done;
  logic [15:0]         mod_rem;
  logic [TimeBits-1:0] tstart_ext;
  job_t                new_job;
  logic [31:0]         miss_next;

  assign cmd_ready_o = (state_q == SIdle);
  assign res_o       = out_q;
  assign res_valid_o = out_v_q;
  assign out_free    = !out_v_q || res_ready_i;
  assign emit_fire   = out_free && ((state_q == SEmitMiss && emit_q != nmiss_q) ||
                                    state_q == SEmitRun || state_q == SEmitLoad);
  assign last_idx    = (idx_q == JobIdxW'(MaxJobs - 1));
  assign ntasks      = (cfg_i.task_count > TaskCntW'(MaxTasks)) ? TaskCntW'(MaxTasks)
                                                                : cfg_i.task_count;
  assign tsel        = tcnt_q[TaskIdxW-1:0];
  assign tstart_ext  = TimeBits'(tstart_q[tsel]);
  assign mod_start   = (state_q == SRelTest) && (tcnt_q < ntasks) && (now_q >= tstart_ext);
  assign miss_next   = sat_inc(miss_cnt_q);

  rmes_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (now_q - tstart_ext),
    .divisor_i  (tper_q[tsel]),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MaxJobs - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = JobIdxW'(i);
      end
    end
  end

  always_comb begin
    new_job.task_idx = tsel;
    new_job.number   = trel_q[tsel] + 16'd1;
    new_job.executed = 16'd0;
    new_job.deadline = now_q + TimeBits'(tper_q[tsel]);
    new_job.period   = tper_q[tsel];
    new_job.total    = texec_q[tsel];
    mem_we           = 1'b0;
    mem_wa           = best_idx_q;
    mem_wd           = best_q;
    mem_wd.executed  = best_q.executed + 16'd1;
    if (state_q == SRelPut && free_found) begin
      mem_we = 1'b1;
      mem_wa = free_idx;
      mem_wd = new_job;
    end else if (state_q == SSelPut && found_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      valid_q    <= '0;
      flag_q     <= '0;
      idx_q      <= '0;
      found_q    <= 1'b0;
      nmiss_q    <= '0;
      emit_q     <= '0;
      tcnt_q     <= '0;
      now_q      <= '0;
      started_q  <= 1'b0;
      miss_cnt_q <= 32'd0;
      busy_cnt_q <= 32'd0;
      ovf_q      <= 1'b0;
      out_v_q    <= 1'b0;
      for (int i = 0; i < MaxTasks; i++) begin
        tstart_q[i] <= 16'd0;
        tper_q[i]   <= 16'd1;
        texec_q[i]  <= 16'd1;
        trel_q[i]   <= 16'd0;
      end
    end else begin
      if (emit_fire) out_v_q <= 1'b1;
      else if (res_ready_i) out_v_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            if (!started_q) begin
              now_q     <= cfg_i.time_base;
              started_q <= 1'b1;
            end
            idx_q   <= '0;
            state_q <= (cmd_i.op == OpLoad) ? SEmitLoad : SDropRd;
          end
        end
        SDropRd: state_q <= SDropEv;
        SDropEv: begin
          if (valid_q[idx_q] && rd_q.executed >= rd_q.total) begin
            valid_q[idx_q] <= 1'b0;
            flag_q[idx_q]  <= 1'b0;
          end else begin
            flag_q[idx_q] <= valid_q[idx_q] && (rd_q.deadline == now_q);
          end
          if (last_idx) begin
            found_q <= 1'b0;
            state_q <= SSortRd;
          end else begin
            state_q <= SDropRd;
          end
          idx_q <= idx_q + 1'b1;
        end
        SSortRd: state_q <= SSortEv;
        SSortEv: begin
          if (flag_q[idx_q] && (!found_q || job_before(cfg_i.policy, rd_q, best_q))) begin
            best_q     <= rd_q;
            best_idx_q <= idx_q;
            found_q    <= 1'b1;
          end
          idx_q   <= idx_q + 1'b1;
          state_q <= last_idx ? SSortPut : SSortRd;
        end
        SSortPut: begin
          found_q <= 1'b0;
          if (found_q) begin
            mbuf_q[nmiss_q[JobIdxW-1:0]] <= best_q;
            nmiss_q                      <= nmiss_q + 1'b1;
            flag_q[best_idx_q]           <= 1'b0;
            if (cfg_i.kill_late) valid_q[best_idx_q] <= 1'b0;
            state_q <= SSortRd;
          end else begin
            tcnt_q  <= '0;
            state_q <= SRelTest;
          end
        end
        SRelTest: begin
          if (tcnt_q >= ntasks) begin
            idx_q   <= '0;
            found_q <= 1'b0;
            state_q <= SSelRd;
          end else if (mod_start) begin
            state_q <= SRelWait;
          end else begin
            tcnt_q <= tcnt_q + 1'b1;
          end
        end
        SRelWait: begin
          if (mod_done) begin
            if (mod_rem == 16'd0) begin
              state_q <= SRelPut;
            end else begin
              tcnt_q  <= tcnt_q + 1'b1;
              state_q <= SRelTest;
            end
          end
        end
        SRelPut: begin
          trel_q[tsel] <= trel_q[tsel] + 16'd1;
          if (free_found) valid_q[free_idx] <= 1'b1;
          else ovf_q <= 1'b1;
          tcnt_q  <= tcnt_q + 1'b1;
          state_q <= SRelTest;
        end
        SSelRd: state_q <= SSelEv;
        SSelEv: begin
          if (valid_q[idx_q] && (!found_q || job_before(cfg_i.policy, rd_q, best_q))) begin
            best_q     <= rd_q;
            best_idx_q <= idx_q;
            found_q    <= 1'b1;
          end
          idx_q   <= idx_q + 1'b1;
          state_q <= last_idx ? SSelPut : SSelRd;
        end
        SSelPut: begin
          best_q.executed <= best_q.executed + 16'd1;
          emit_q          <= '0;
          state_q         <= SEmitMiss;
        end
        SEmitMiss: begin
          if (emit_q == nmiss_q) begin
            state_q <= SEmitRun;
          end else if (out_free) begin
            out_q.kind         <= KindMiss;
            out_q.task_id      <= 4'(mbuf_q[emit_q[JobIdxW-1:0]].task_idx) + 4'd1;
            out_q.job_id       <= mbuf_q[emit_q[JobIdxW-1:0]].number;
            out_q.exec_done    <= mbuf_q[emit_q[JobIdxW-1:0]].executed;
            out_q.exec_total   <= mbuf_q[emit_q[JobIdxW-1:0]].total;
            out_q.tick_time    <= now_q;
            out_q.miss_total   <= miss_next;
            out_q.busy_total   <= busy_cnt_q;
            out_q.job_overflow <= ovf_q;
            out_q.last         <= 1'b0;
            miss_cnt_q         <= miss_next;
            emit_q             <= emit_q + 1'b1;
          end
        end
        SEmitRun: begin
          if (out_free) begin
            out_q.tick_time    <= now_q;
            out_q.miss_total   <= miss_cnt_q;
            out_q.job_overflow <= ovf_q;
            out_q.last         <= 1'b1;
            if (found_q) begin
              out_q.kind       <= KindRun;
              out_q.task_id    <= 4'(best_q.task_idx) + 4'd1;
              out_q.job_id     <= best_q.number;
              out_q.exec_done  <= best_q.executed;
              out_q.exec_total <= best_q.total;
              out_q.busy_total <= sat_inc(busy_cnt_q);
              busy_cnt_q       <= sat_inc(busy_cnt_q);
            end else begin
              out_q.kind       <= KindIdle;
              out_q.task_id    <= 4'd0;
              out_q.job_id     <= 16'd0;
              out_q.exec_done  <= 16'd0;
              out_q.exec_total <= 16'd0;
              out_q.busy_total <= busy_cnt_q;
            end
            ovf_q   <= 1'b0;
            nmiss_q <= '0;
            now_q   <= now_q + 1'b1;
            state_q <= SIdle;
          end
        end
        SEmitLoad: begin
          if (out_free) begin
            tstart_q[cmd_q.task_index] <= cmd_q.task_start;
            tper_q[cmd_q.task_index]   <= cmd_q.task_period;
            texec_q[cmd_q.task_index]  <= cmd_q.task_exec;
            trel_q[cmd_q.task_index]   <= 16'd0;
            out_q.kind         <= KindLoad;
            out_q.task_id      <= {1'b0, cmd_q.task_index} + 4'd1;
            out_q.job_id       <= 16'd0;
            out_q.exec_done    <= 16'd0;
            out_q.exec_total   <= cmd_q.task_exec;
            out_q.tick_time    <= now_q;
            out_q.miss_total   <= miss_cnt_q;
            out_q.busy_total   <= busy_cnt_q;
            out_q.job_overflow <= 1'b0;
            out_q.last         <= 1'b1;
            state_q            <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  a_rise_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> ($past(state_q) == SEmitMiss || $past(state_q) == SEmitRun ||
                        $past(state_q) == SEmitLoad))
    else $error("result raised outside an emit state");

  a_nmiss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nmiss_q <= JobCntW'(MaxJobs)) else $error("miss count exceeds job store");

  a_mod_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == SRelWait) else $error("remainder done while not waiting");

endmodule
